### rtl/cws_pkg.sv
// Shared widths, register map and reset values of the checker wipe cell scheduler.
`default_nettype none

package cws_pkg;

    // Item field widths
    localparam int STEP_W  = 16;
    localparam int COORD_W = 12;
    localparam int PAINT_W = 13;
    localparam int CELL_W  = 8;
    localparam int COLOR_W = 8;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register indexes, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_RECT_LEFT   = 3'd0,
        REG_RECT_TOP    = 3'd1,
        REG_RECT_WIDTH  = 3'd2,
        REG_RECT_HEIGHT = 3'd3,
        REG_FRAME_COUNT = 3'd4,
        REG_CELL_SIZE   = 3'd5,
        REG_FILL_COLOR  = 3'd6
    } cws_reg_t;

    // Register reset values
    localparam logic [COORD_W-1:0] RST_RECT_LEFT   = 12'd0;
    localparam logic [COORD_W-1:0] RST_RECT_TOP    = 12'd0;
    localparam logic [COORD_W-1:0] RST_RECT_WIDTH  = 12'd640;
    localparam logic [COORD_W-1:0] RST_RECT_HEIGHT = 12'd400;
    localparam logic [STEP_W-1:0]  RST_FRAME_COUNT = 16'd30;
    localparam logic [CELL_W-1:0]  RST_CELL_SIZE   = 8'd80;
    localparam logic [COLOR_W-1:0] RST_FILL_COLOR  = 8'd0;

endpackage

`default_nettype wire

### rtl/cws_if.sv
// Valid/ready channels: frame step items in, paint rectangle items out.
`default_nettype none

interface cws_step_if;
    logic                        valid;
    logic                        ready;
    logic [cws_pkg::STEP_W-1:0]  frame_step;

    modport source (output valid, output frame_step, input ready);
    modport sink   (input valid, input frame_step, output ready);
endinterface

interface cws_paint_if;
    logic                         valid;
    logic                         ready;
    logic [cws_pkg::PAINT_W-1:0]  paint_x;
    logic [cws_pkg::PAINT_W-1:0]  paint_y;
    logic [cws_pkg::COORD_W-1:0]  paint_w;
    logic [cws_pkg::COORD_W-1:0]  paint_h;
    logic                         painted;
    logic                         last_of_step;

    modport source (output valid, output paint_x, output paint_y, output paint_w,
                    output paint_h, output painted, output last_of_step, input ready);
    modport sink   (input valid, input paint_x, input paint_y, input paint_w,
                    input paint_h, input painted, input last_of_step, output ready);
endinterface

`default_nettype wire

### rtl/checker_wipe_cell_scheduler.sv
// Top level: checkered diagonal wipe scheduler with serial rank divider and cell scan.
//
// Each frame_step item yields the rectangles of all cells that fire at that step, in row
// order, the final one marked last_of_step; if none fires a single item with painted low
// comes out. The block works on one item at a time and takes the next once the last result
// sits in the output register. Per item it counts columns and rows by repeated subtraction,
// then for every rank r = 0 .. R (R = cols + rows - 2) runs one multiply step, a restoring
// divide of one quotient bit per cycle over a dividend of 16 + bits of 2 * (MAX_COLS +
// MAX_ROWS - 2) bits (21 at the default size) and one compare step, then scans one cell per
// cycle while the output does not stall. An empty grid or a zero frame count goes straight
// to the flush. Registers sit at byte addresses 4*i.
`default_nettype none

module checker_wipe_cell_scheduler #(
    parameter int MAX_COLS = 8,
    parameter int MAX_ROWS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    cws_step_if.sink                            step_in,
    cws_paint_if.source                         paint_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cws_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [cws_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [cws_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import cws_pkg::*;

    localparam int MAX_DIM  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int CNT_W    = $clog2(MAX_DIM + 1);
    localparam int RANK_MAX = MAX_COLS + MAX_ROWS - 2;
    localparam int RANK_N   = RANK_MAX + 1;
    localparam int RANK_W   = (RANK_N > 1) ? $clog2(RANK_N) : 1;
    localparam int NUM_W    = (RANK_MAX > 0) ? $clog2(2 * RANK_MAX + 1) : 1;
    localparam int PROD_W   = STEP_W + NUM_W;
    localparam int DCNT_W   = $clog2(PROD_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COLS,
        S_ROWS,
        S_MUL,
        S_DIV,
        S_CMP,
        S_SCAN,
        S_FLUSH
    } state_t;

    // Configuration registers
    logic [COORD_W-1:0] rect_left_reg;
    logic [COORD_W-1:0] rect_top_reg;
    logic [COORD_W-1:0] rect_width_reg;
    logic [COORD_W-1:0] rect_height_reg;
    logic [STEP_W-1:0]  frame_count_reg;
    logic [CELL_W-1:0]  cell_size_reg;
    logic [COLOR_W-1:0] fill_color_reg;

    // Control and datapath registers
    state_t             state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [COORD_W-1:0] rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cols_reg;
    logic [CNT_W-1:0]   rows_reg;
    logic [RANK_W-1:0]  r_reg;
    logic [PROD_W-1:0]  dq_reg;
    logic [NUM_W-1:0]   drem_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [RANK_N-1:0]  match_reg;
    logic [CNT_W-1:0]   i_reg;
    logic [CNT_W-1:0]   j_reg;
    logic [COORD_W-1:0] x0_reg;
    logic [COORD_W-1:0] y0_reg;
    logic               hold_valid_reg;
    logic [PAINT_W-1:0] hold_x_reg;
    logic [PAINT_W-1:0] hold_y_reg;
    logic [COORD_W-1:0] hold_w_reg;
    logic [COORD_W-1:0] hold_h_reg;
    logic               out_valid_reg;
    logic [PAINT_W-1:0] out_x_reg;
    logic [PAINT_W-1:0] out_y_reg;
    logic [COORD_W-1:0] out_w_reg;
    logic [COORD_W-1:0] out_h_reg;
    logic               out_painted_reg;
    logic               out_last_reg;

    // Combinational helpers
    logic               cfg_wr;
    cws_reg_t           cfg_idx;
    logic [COORD_W-1:0] cell_ext;
    logic [STEP_W-1:0]  fm1;
    logic [RANK_W-1:0]  maxr;
    logic [NUM_W-1:0]   num;
    logic [NUM_W-1:0]   divisor;
    logic [PROD_W-1:0]  prod;
    logic [NUM_W:0]     trial;
    logic               q_bit;
    logic [NUM_W-1:0]   drem_next;
    logic               act_hit;
    logic               col_last;
    logic               row_last;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COORD_W-1:0] cur_w;
    logic [COORD_W-1:0] cur_h;
    logic [PAINT_W-1:0] cur_x;
    logic [PAINT_W-1:0] cur_y;
    logic [RANK_W-1:0]  cur_rank;
    logic               cur_hit;
    logic               out_free;
    logic               scan_stall;
    logic               out_load;

    // Configuration write and read
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cws_reg_t'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg   <= RST_RECT_LEFT;
            rect_top_reg    <= RST_RECT_TOP;
            rect_width_reg  <= RST_RECT_WIDTH;
            rect_height_reg <= RST_RECT_HEIGHT;
            frame_count_reg <= RST_FRAME_COUNT;
            cell_size_reg   <= RST_CELL_SIZE;
            fill_color_reg  <= RST_FILL_COLOR;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_RECT_LEFT:   rect_left_reg   <= pwdata[COORD_W-1:0];
                REG_RECT_TOP:    rect_top_reg    <= pwdata[COORD_W-1:0];
                REG_RECT_WIDTH:  rect_width_reg  <= pwdata[COORD_W-1:0];
                REG_RECT_HEIGHT: rect_height_reg <= pwdata[COORD_W-1:0];
                REG_FRAME_COUNT: frame_count_reg <= pwdata[STEP_W-1:0];
                REG_CELL_SIZE:   cell_size_reg   <= pwdata[CELL_W-1:0];
                REG_FILL_COLOR:  fill_color_reg  <= pwdata[COLOR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_RECT_LEFT:   prdata = APB_DATA_W'(rect_left_reg);
            REG_RECT_TOP:    prdata = APB_DATA_W'(rect_top_reg);
            REG_RECT_WIDTH:  prdata = APB_DATA_W'(rect_width_reg);
            REG_RECT_HEIGHT: prdata = APB_DATA_W'(rect_height_reg);
            REG_FRAME_COUNT: prdata = APB_DATA_W'(frame_count_reg);
            REG_CELL_SIZE:   prdata = APB_DATA_W'(cell_size_reg);
            REG_FILL_COLOR:  prdata = APB_DATA_W'(fill_color_reg);
            default:         prdata = '0;
        endcase
    end

    // Grid geometry and rank activation math
    assign cell_ext   = COORD_W'(cell_size_reg);
    assign fm1        = frame_count_reg - STEP_W'(1);
    assign maxr       = RANK_W'({1'b0, cols_reg} + {1'b0, rows_reg} - (CNT_W + 1)'(2));
    assign num        = r_reg[0] ? (NUM_W'(maxr) + NUM_W'(r_reg)) : NUM_W'(r_reg);
    assign divisor    = NUM_W'({maxr, 1'b0});
    assign prod       = PROD_W'(fm1) * PROD_W'(num);

    // Restoring divide: one quotient bit per cycle
    assign trial     = {drem_reg, dq_reg[PROD_W-1]};
    assign q_bit     = (trial >= {1'b0, divisor});
    assign drem_next = q_bit ? NUM_W'(trial - {1'b0, divisor}) : trial[NUM_W-1:0];

    // Clamp quotient to the last frame and match against the step
    assign act_hit = (dq_reg > PROD_W'(fm1)) ? (fm1 == step_reg)
                                             : (dq_reg == PROD_W'(step_reg));

    // Current cell of the scan, trailing cells stretch to the edge
    assign col_last = (i_reg == cols_reg - CNT_W'(1));
    assign row_last = (j_reg == rows_reg - CNT_W'(1));
    assign x_end    = col_last ? rect_width_reg : (x0_reg + cell_ext);
    assign y_end    = row_last ? rect_height_reg : (y0_reg + cell_ext);
    assign cur_w    = x_end - x0_reg;
    assign cur_h    = y_end - y0_reg;
    assign cur_x    = {1'b0, rect_left_reg} + {1'b0, x0_reg};
    assign cur_y    = {1'b0, rect_top_reg} + {1'b0, y0_reg};
    assign cur_rank = RANK_W'({1'b0, i_reg} + {1'b0, j_reg});
    assign cur_hit  = match_reg[cur_rank];

    assign out_free   = !out_valid_reg || paint_out.ready;
    assign scan_stall = cur_hit && hold_valid_reg && !out_free;

    // A new output item enters from the scan or from the flush
    assign out_load = ((state_reg == S_SCAN) && !scan_stall && cur_hit && hold_valid_reg)
                      || ((state_reg == S_FLUSH) && out_free);

    // Ports
    assign step_in.ready          = (state_reg == S_IDLE);
    assign paint_out.valid        = out_valid_reg;
    assign paint_out.paint_x      = out_x_reg;
    assign paint_out.paint_y      = out_y_reg;
    assign paint_out.paint_w      = out_w_reg;
    assign paint_out.paint_h      = out_h_reg;
    assign paint_out.painted      = out_painted_reg;
    assign paint_out.last_of_step = out_last_reg;

    // Sequencer: count grid, rate each rank, scan cells, emit items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= '0;
            rem_reg         <= '0;
            cnt_reg         <= '0;
            cols_reg        <= '0;
            rows_reg        <= '0;
            r_reg           <= '0;
            dq_reg          <= '0;
            drem_reg        <= '0;
            dcnt_reg        <= '0;
            match_reg       <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            x0_reg          <= '0;
            y0_reg          <= '0;
            hold_valid_reg  <= 1'b0;
            hold_x_reg      <= '0;
            hold_y_reg      <= '0;
            hold_w_reg      <= '0;
            hold_h_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_w_reg       <= '0;
            out_h_reg       <= '0;
            out_painted_reg <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            // Load a new output item, or drop the current one once taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (paint_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (step_in.valid)
                    begin
                        step_reg       <= step_in.frame_step;
                        rem_reg        <= rect_width_reg;
                        cnt_reg        <= '0;
                        hold_valid_reg <= 1'b0;
                        state_reg      <= S_COLS;
                    end
                end

                S_COLS:
                begin
                    if ((cell_size_reg != '0) && (rem_reg >= cell_ext)
                        && (cnt_reg != CNT_W'(MAX_COLS)))
                    begin
                        rem_reg <= rem_reg - cell_ext;
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        cols_reg  <= cnt_reg;
                        rem_reg   <= rect_height_reg;
                        cnt_reg   <= '0;
                        state_reg <= S_ROWS;
                    end
                end

                S_ROWS:
                begin
                    if ((cell_size_reg != '0) && (rem_reg >= cell_ext)
                        && (cnt_reg != CNT_W'(MAX_ROWS)))
                    begin
                        rem_reg <= rem_reg - cell_ext;
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        rows_reg <= cnt_reg;
                        r_reg    <= '0;
                        i_reg    <= '0;
                        j_reg    <= '0;
                        x0_reg   <= '0;
                        y0_reg   <= '0;
                        if ((cols_reg == '0) || (cnt_reg == '0) || (frame_count_reg == '0))
                        begin
                            state_reg <= S_FLUSH;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end

                S_MUL:
                begin
                    if (maxr == '0)
                    begin
                        // Single cell grid fires at step zero
                        match_reg[0] <= (step_reg == '0);
                        state_reg    <= S_SCAN;
                    end
                    else
                    begin
                        dq_reg    <= prod;
                        drem_reg  <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    dq_reg   <= {dq_reg[PROD_W-2:0], q_bit};
                    drem_reg <= drem_next;
                    dcnt_reg <= dcnt_reg + DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(PROD_W - 1))
                    begin
                        state_reg <= S_CMP;
                    end
                end

                S_CMP:
                begin
                    match_reg[r_reg] <= act_hit;
                    if (r_reg == maxr)
                    begin
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        r_reg     <= r_reg + RANK_W'(1);
                        state_reg <= S_MUL;
                    end
                end

                S_SCAN:
                begin
                    if (!scan_stall)
                    begin
                        if (cur_hit)
                        begin
                            // Release the held item, hold the new one
                            if (hold_valid_reg)
                            begin
                                out_x_reg       <= hold_x_reg;
                                out_y_reg       <= hold_y_reg;
                                out_w_reg       <= hold_w_reg;
                                out_h_reg       <= hold_h_reg;
                                out_painted_reg <= 1'b1;
                                out_last_reg    <= 1'b0;
                            end
                            hold_valid_reg <= 1'b1;
                            hold_x_reg     <= cur_x;
                            hold_y_reg     <= cur_y;
                            hold_w_reg     <= cur_w;
                            hold_h_reg     <= cur_h;
                        end

                        // Advance the scan row by row
                        if (col_last)
                        begin
                            i_reg  <= '0;
                            x0_reg <= '0;
                            j_reg  <= j_reg + CNT_W'(1);
                            y0_reg <= y0_reg + cell_ext;
                            if (row_last)
                            begin
                                state_reg <= S_FLUSH;
                            end
                        end
                        else
                        begin
                            i_reg  <= i_reg + CNT_W'(1);
                            x0_reg <= x0_reg + cell_ext;
                        end
                    end
                end

                S_FLUSH:
                begin
                    if (out_free)
                    begin
                        out_last_reg  <= 1'b1;
                        if (hold_valid_reg)
                        begin
                            out_x_reg       <= hold_x_reg;
                            out_y_reg       <= hold_y_reg;
                            out_w_reg       <= hold_w_reg;
                            out_h_reg       <= hold_h_reg;
                            out_painted_reg <= 1'b1;
                        end
                        else
                        begin
                            out_x_reg       <= '0;
                            out_y_reg       <= '0;
                            out_w_reg       <= '0;
                            out_h_reg       <= '0;
                            out_painted_reg <= 1'b0;
                        end
                        hold_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/cws_checker.sv
// Port-level checks of the checker wipe cell scheduler, bound to the top level.
`default_nettype none

module cws_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [cws_pkg::PAINT_W-1:0]   paint_x,
    input wire logic [cws_pkg::PAINT_W-1:0]   paint_y,
    input wire logic [cws_pkg::COORD_W-1:0]   paint_w,
    input wire logic [cws_pkg::COORD_W-1:0]   paint_h,
    input wire logic                          painted,
    input wire logic                          last_of_step
);
    import cws_pkg::*;

    // Hold a stalled output item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(paint_x) && $stable(paint_y)
            && $stable(paint_w) && $stable(paint_h) && $stable(painted)
            && $stable(last_of_step))
        else $error("stalled output item changed");

    // One item at a time: ready drops after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // An empty result closes the step and carries no rectangle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !painted |-> last_of_step && (paint_x == '0) && (paint_y == '0)
            && (paint_w == '0) && (paint_h == '0))
        else $error("empty result malformed");

    // A painted cell is never degenerate
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && painted |-> (paint_w != '0) && (paint_h != '0))
        else $error("painted cell has zero size");

endmodule

bind checker_wipe_cell_scheduler cws_checker u_cws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (step_in.valid),
    .in_ready     (step_in.ready),
    .out_valid    (paint_out.valid),
    .out_ready    (paint_out.ready),
    .paint_x      (paint_out.paint_x),
    .paint_y      (paint_out.paint_y),
    .paint_w      (paint_out.paint_w),
    .paint_h      (paint_out.paint_h),
    .painted      (paint_out.painted),
    .last_of_step (paint_out.last_of_step)
);

`default_nettype wire
